// ===== rtl/dba_pkg.sv =====
// ----------------------------------------------------------------------------
// dba_pkg
// Shared types and constants of the packed BCD decimal ALU.
// ----------------------------------------------------------------------------
package dba_pkg;

  localparam int unsigned MaxDigits = 16;
  localparam int unsigned WordW     = 4 * MaxDigits;

  typedef enum logic [2:0] {
    FUNC_ADD = 3'd0,
    FUNC_SUB = 3'd1,
    FUNC_MUL = 3'd2,
    FUNC_DIV = 3'd3,
    FUNC_CMP = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_CARRY  = 2'd1,
    ST_BORROW = 2'd2,
    ST_DIVZ   = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]       func;
    logic [WordW-1:0] operand_a;
    logic [WordW-1:0] operand_b;
  } in_req_t;

  typedef struct packed {
    logic [WordW-1:0] result_digits;
    logic             less_flag;
    logic             equal_flag;
    logic             greater_flag;
    logic [1:0]       status;
  } out_req_t;

  // Shared digit unit control.
  typedef struct packed {
    logic       sub;     // subtract b digit with borrow, else add with carry
    logic [3:0] a_dig;
    logic [3:0] b_dig;
    logic       cin;
  } du_ctl_t;

  typedef struct packed {
    logic [3:0] sum;
    logic       cout;
  } du_res_t;

endpackage

// ===== rtl/dba_digit_unit.sv =====
// ----------------------------------------------------------------------------
// dba_digit_unit
// One-digit BCD adder/subtractor with carry or borrow in and out.
// ----------------------------------------------------------------------------
module dba_digit_unit (
  input  dba_pkg::du_ctl_t ctl,
  output dba_pkg::du_res_t res
);
  import dba_pkg::*;

  logic [4:0] raw;

  always_comb begin
    raw = '0;
    res = '0;
    if (ctl.sub) begin
      raw = {1'b0, ctl.a_dig} - {1'b0, ctl.b_dig} - {4'd0, ctl.cin};
      if (raw[4]) begin
        res.sum  = 4'(raw[3:0] + 4'd10);
        res.cout = 1'b1;
      end else begin
        res.sum  = raw[3:0];
        res.cout = 1'b0;
      end
    end else begin
      raw = {1'b0, ctl.a_dig} + {1'b0, ctl.b_dig} + {4'd0, ctl.cin};
      if (raw > 5'd9) begin
        res.sum  = 4'(raw - 5'd10);
        res.cout = 1'b1;
      end else begin
        res.sum  = raw[3:0];
        res.cout = 1'b0;
      end
    end
  end

endmodule

// ===== rtl/decimal_bcd_alu.sv =====
// ----------------------------------------------------------------------------
// decimal_bcd_alu
// Packed BCD decimal ALU: add, subtract, multiply, divide and compare on
// unsigned DIGITS-digit operands, built around one shared digit unit.
// ----------------------------------------------------------------------------
//
//   channel  ports                          handshake
//   -------  -----------------------------  ------------------------------
//   request  in_req (func, operands)        taken when start && !busy
//   result   out_res (digits, flags, stat)  out_valid high for one cycle
//
// Sequence: one request is worked digit-serially through the shared digit unit.
//   Every request opens with a digit-serial a - b pass that sets the flags.
//   Compare, unused codes and divide by zero finish after it; add/subtract
//   take a second pass. Multiply adds a into the partial product once per
//   unit of each b digit, each add walking every digit plus a carry step,
//   with one sequencing step per add and per digit. Divide is restoring
//   long division: per quotient digit one shift step, up to ten subtract
//   passes and one step to the next digit. The result is shown through a
//   done state and the registered out_valid.
// Reset: synchronous active-low rst_n clears the sequencer; busy drops.
// Stalls: the receiver cannot stall; out_valid pulses for one cycle, during
//   which busy is already low and the next request may be taken.
//
module decimal_bcd_alu #(
  parameter int unsigned DIGITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  dba_pkg::in_req_t  in_req,
  output logic              out_valid,
  output dba_pkg::out_req_t out_res
);
  import dba_pkg::*;

  localparam int unsigned DW = 4 * DIGITS;
  localparam int unsigned IW = $clog2(DIGITS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CMP, S_ADD, S_MADD, S_MNEXT, S_DSHIFT, S_DSUB, S_DNEXT, S_DONE
  } state_t;

  state_t      state_r;
  logic [2:0]  func_r;
  // a and b hold sanitized digits; acc is the working accumulator.
  logic [DW-1:0] a_r, b_r, acc_r, tmp_r, q_r;
  // Multiply: acc holds the low product digits, hi the upper ones.
  logic [DW-1:0] hi_r;          // multiply upper product digits
  logic [IW-1:0] idx_r;         // digit position within a pass
  logic [IW-1:0] pos_r;         // outer digit position
  logic [3:0]    cnt_r;         // repeat count for the current outer digit
  logic          carry_r;
  logic [DW-1:0] res_r;
  logic [1:0]    stat_r;
  logic          ov_r;

  du_ctl_t du_ctl;
  du_res_t du_res;

  dba_digit_unit u_du (.ctl(du_ctl), .res(du_res));

  function automatic logic [WordW-1:0] sanitize(input logic [WordW-1:0] x);
    logic [WordW-1:0] y;
    y = '0;
    for (int i = 0; i < MaxDigits; i++) begin
      if (i < DIGITS) y[4*i +: 4] = (x[4*i +: 4] > 4'd9) ? 4'd9 : x[4*i +: 4];
    end
    return y;
  endfunction

  logic [WordW-1:0] a_san, b_san;
  assign a_san = sanitize(in_req.operand_a);
  assign b_san = sanitize(in_req.operand_b);

  logic [3:0] dig_a, dig_b;
  logic [IW-1:0] last_idx;
  assign last_idx = IW'(DIGITS - 1);

  // Digit position in {hi,acc} for multiply add.
  logic [IW:0]  mpos;
  logic [3:0]   mdig;
  logic [IW:0]  hpos;
  always_comb begin
    mpos = {1'b0, idx_r} + {1'b0, pos_r};
    hpos = (IW+1)'(mpos - (IW+1)'(DIGITS));
    if (mpos < (IW+1)'(DIGITS)) mdig = acc_r[4*mpos[IW-1:0] +: 4];
    else                        mdig = hi_r[4*hpos[IW-1:0] +: 4];
  end

  // Operand selection for the digit unit by state.
  always_comb begin
    du_ctl = '0;
    dig_a  = '0;
    dig_b  = '0;
    case (state_r)
      S_CMP: begin
        du_ctl.sub = 1'b1;
        dig_a = a_r[4*idx_r +: 4];
        dig_b = b_r[4*idx_r +: 4];
      end
      S_ADD: begin
        du_ctl.sub = (func_r == FUNC_SUB);
        dig_a = a_r[4*idx_r +: 4];
        dig_b = b_r[4*idx_r +: 4];
      end
      S_MADD: begin
        // add a shifted by pos into {hi,acc}; idx runs 0..DIGITS over a,
        // and the last step walks the carry into the next digit.
        dig_a = mdig;
        dig_b = (idx_r < IW'(DIGITS)) ? a_r[4*idx_r +: 4] : 4'd0;
      end
      S_DSUB: begin
        du_ctl.sub = 1'b1;
        dig_a = tmp_r[4*idx_r +: 4];
        dig_b = b_r[4*idx_r +: 4];
      end
      default: ;
    endcase
    du_ctl.a_dig = dig_a;
    du_ctl.b_dig = dig_b;
    du_ctl.cin   = carry_r;
  end

  logic [DW-1:0] shifted;
  assign shifted = {tmp_r[DW-5:0], a_r[4*pos_r +: 4]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= (state_r == S_DONE);
      case (state_r)
        S_IDLE: begin
          if (start) begin
            func_r  <= in_req.func;
            a_r     <= a_san[DW-1:0];
            b_r     <= b_san[DW-1:0];
            idx_r   <= '0;
            carry_r <= 1'b0;
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          // a - b digit-serial: final borrow gives less.
          if (idx_r == last_idx) begin
            idx_r   <= '0;
            carry_r <= 1'b0;
            ov_r    <= du_res.cout;
            res_r   <= '0;
            stat_r  <= (func_r == FUNC_DIV && b_r == '0) ? ST_DIVZ : ST_OK;
            case (func_r)
              FUNC_MUL: begin
                acc_r <= '0; hi_r <= '0; pos_r <= '0; cnt_r <= '0;
                state_r <= S_MNEXT;
              end
              FUNC_DIV: begin
                tmp_r <= '0; q_r <= '0; pos_r <= last_idx;
                state_r <= (b_r == '0) ? S_DONE : S_DSHIFT;
              end
              FUNC_ADD, FUNC_SUB: state_r <= S_ADD;
              default: state_r <= S_DONE;
            endcase
          end else begin
            carry_r <= du_res.cout;
            idx_r   <= idx_r + 1'b1;
          end
        end
        S_ADD: begin
          res_r[4*idx_r +: 4] <= du_res.sum;
          if (idx_r == last_idx) begin
            if (du_res.cout)
              stat_r <= (func_r == FUNC_SUB) ? ST_BORROW : ST_CARRY;
            state_r <= S_DONE;
          end else begin
            carry_r <= du_res.cout;
            idx_r   <= idx_r + 1'b1;
          end
        end
        S_MNEXT: begin
          // pick next multiplier digit count, or finish
          if (cnt_r == b_r[4*pos_r +: 4]) begin
            cnt_r <= '0;
            if (pos_r == last_idx) begin
              res_r  <= acc_r;
              stat_r <= (hi_r != '0) ? ST_CARRY : ST_OK;
              state_r <= S_DONE;
            end else begin
              pos_r <= pos_r + 1'b1;
            end
          end else begin
            cnt_r   <= cnt_r + 1'b1;
            idx_r   <= '0;
            carry_r <= 1'b0;
            state_r <= S_MADD;
          end
        end
        S_MADD: begin
          // one digit of {hi,acc} += a << pos per step; idx runs 0..DIGITS
          if (mpos < (IW+1)'(DIGITS)) acc_r[4*mpos[IW-1:0] +: 4] <= du_res.sum;
          else                        hi_r[4*hpos[IW-1:0] +: 4]  <= du_res.sum;
          carry_r <= du_res.cout;
          if (idx_r == IW'(DIGITS)) state_r <= S_MNEXT;
          else                      idx_r   <= idx_r + 1'b1;
        end
        S_DSHIFT: begin
          // bring down digit pos of a into the remainder
          tmp_r   <= shifted;
          idx_r   <= '0;
          carry_r <= 1'b0;
          cnt_r   <= '0;
          state_r <= S_DSUB;
        end
        S_DSUB: begin
          if (idx_r == last_idx) begin
            idx_r   <= '0;
            carry_r <= 1'b0;
            if (du_res.cout) begin
              // remainder below b: keep tmp, record quotient digit
              q_r[4*pos_r +: 4] <= cnt_r;
              state_r <= S_DNEXT;
            end else begin
              tmp_r <= {du_res.sum, acc_r[DW-5:0]};
              cnt_r <= cnt_r + 1'b1;
            end
          end else begin
            acc_r[4*idx_r +: 4] <= du_res.sum;
            carry_r <= du_res.cout;
            idx_r   <= idx_r + 1'b1;
          end
        end
        S_DNEXT: begin
          if (pos_r == '0) begin
            res_r   <= q_r;
            state_r <= S_DONE;
          end else begin
            pos_r   <= pos_r - 1'b1;
            state_r <= S_DSHIFT;
          end
        end
        S_DONE: begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Relation flags from the compare pass: ov holds the borrow of a - b.
  assign busy = (state_r != S_IDLE);

  always_comb begin
    out_res               = '0;
    out_res.result_digits = WordW'(res_r);
    out_res.less_flag     = ov_r;
    out_res.equal_flag    = (a_r == b_r);
    out_res.greater_flag  = !ov_r && (a_r != b_r);
    out_res.status        = stat_r;
  end

endmodule

// ===== tb/sv/tb_decimal_bcd_alu.sv =====
// ----------------------------------------------------------------------------
// tb_decimal_bcd_alu
// Self-checking bench for the packed BCD decimal ALU: directed corner
// requests, then random requests under several idle phases, each result
// compared field by field against an in-bench digit predictor.
// ----------------------------------------------------------------------------
module tb_decimal_bcd_alu;
  timeunit 1ns;
  timeprecision 1ps;
  import dba_pkg::*;

  localparam int unsigned NDig = 16;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  in_req_t  in_req;
  logic     out_valid;
  out_req_t out_res;

  in_req_t  pending_reqs[$];
  out_req_t expected_results[$];
  int       mismatch_count;
  int       idle_pct;
  logic     stim_done;

  decimal_bcd_alu #(.DIGITS(NDig)) u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_res(out_res)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Convert packed BCD to a binary value; nibbles above 9 read as 9.
  function automatic logic [127:0] bcd_value(input logic [63:0] x);
    logic [127:0] v;
    logic [3:0]   nib;
    v = '0;
    for (int i = NDig - 1; i >= 0; i--) begin
      nib = x[4*i +: 4];
      v = v * 10 + ((nib > 4'd9) ? 4'd9 : nib);
    end
    return v;
  endfunction

  // Pack the low NDig decimal digits of a value.
  function automatic logic [63:0] bcd_pack(input logic [127:0] v);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < NDig; i++) begin
      r[4*i +: 4] = 4'(v % 10);
      v = v / 10;
    end
    return r;
  endfunction

  // Predict the result of one request. Work in 128 bits so products fit.
  function automatic out_req_t alu_predict(input in_req_t rq);
    out_req_t     r;
    logic [127:0] a, b, m;
    a = bcd_value(rq.operand_a);
    b = bcd_value(rq.operand_b);
    m = 1;
    for (int i = 0; i < NDig; i++) m = m * 10;
    r = '0;
    r.status = ST_OK;
    case (rq.func)
      FUNC_ADD: begin
        r.result_digits = bcd_pack(a + b);
        if (a + b >= m) r.status = ST_CARRY;
      end
      FUNC_SUB: begin
        if (a < b) begin
          r.result_digits = bcd_pack(a + m - b);
          r.status = ST_BORROW;
        end else begin
          r.result_digits = bcd_pack(a - b);
        end
      end
      FUNC_MUL: begin
        r.result_digits = bcd_pack(a * b);
        if (a * b >= m) r.status = ST_CARRY;
      end
      FUNC_DIV: begin
        if (b == 0) r.status = ST_DIVZ;
        else r.result_digits = bcd_pack(a / b);
      end
      default: r.result_digits = '0; // compare and unused codes
    endcase
    // The comparator runs on every operation.
    r.less_flag    = (a < b);
    r.equal_flag   = (a == b);
    r.greater_flag = (a > b);
    return r;
  endfunction

  // Build a random operand: mostly legal BCD, sometimes raw nibbles,
  // with a random length of 0 to NDig digits so multiply and divide stay varied.
  function automatic logic [63:0] rand_operand();
    logic [63:0] x;
    int          len;
    int          mode;
    x = '0;
    mode = $urandom_range(0, 9);
    len = $urandom_range(0, NDig);
    if (mode == 0) begin
      x = {$urandom, $urandom};
    end else begin
      for (int i = 0; i < len; i++) x[4*i +: 4] = 4'($urandom_range(0, 9));
      if (mode == 1) x[4*$urandom_range(0, NDig-1) +: 4] = 4'($urandom_range(10, 15));
    end
    return x;
  endfunction

  function automatic in_req_t mk_req(input logic [2:0] f, input logic [63:0] a,
                                     input logic [63:0] b);
    in_req_t rq;
    rq.func = f;
    rq.operand_a = a;
    rq.operand_b = b;
    return rq;
  endfunction

  // Driver: hold start until the request is taken, then advance.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      expected_results.push_back(alu_predict(in_req));
      void'(pending_reqs.pop_front());
      if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        in_req <= pending_reqs[0];
        start  <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end else if (!start && pending_reqs.size() > 0 &&
                 $urandom_range(0, 99) >= idle_pct) begin
      in_req <= pending_reqs[0];
      start  <= 1'b1;
    end
  end

  // Monitor: compare each strobed result with the oldest expectation.
  always @(posedge clk) begin
    out_req_t exp_r;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %p", out_res);
      end else begin
        exp_r = expected_results.pop_front();
        if (out_res.result_digits !== exp_r.result_digits ||
            out_res.less_flag !== exp_r.less_flag ||
            out_res.equal_flag !== exp_r.equal_flag ||
            out_res.greater_flag !== exp_r.greater_flag ||
            out_res.status !== exp_r.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected %p actual %p", exp_r, out_res);
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [63:0] nines;
    int          phase_idle[4];
    nines = 64'h9999_9999_9999_9999;
    // no idling, sender idle, receiver phase (cannot stall), both
    phase_idle = '{0, 66, 0, 13};
    mismatch_count = 0;
    idle_pct = 0;
    stim_done = 1'b0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed corners: every operation at the extremes.
    for (int f = 0; f < 5; f++) begin
      pending_reqs.push_back(mk_req(3'(f), '0, '0));
      pending_reqs.push_back(mk_req(3'(f), nines, nines));
      pending_reqs.push_back(mk_req(3'(f), nines, 64'h1));
      pending_reqs.push_back(mk_req(3'(f), 64'h1, nines));
    end
    pending_reqs.push_back(mk_req(FUNC_DIV, 64'h1234, '0));            // divide by zero
    pending_reqs.push_back(mk_req(FUNC_ADD, '1, 64'h0));               // bad nibbles read as 9
    pending_reqs.push_back(mk_req(FUNC_MUL, 64'hFFFF_FFFF, 64'hABCD)); // bad nibbles in multiply
    pending_reqs.push_back(mk_req(3'd5, 64'h5, 64'h7));                // unused codes compare
    pending_reqs.push_back(mk_req(3'd7, '1, 64'h7));
    wait (pending_reqs.size() == 0);

    // Random phases, each with its own sender idle rate from phase_idle.
    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_idle[p];
      for (int n = 0; n < 488; n++)
        pending_reqs.push_back(mk_req(3'($urandom_range(0, 7)),
                                      rand_operand(), rand_operand()));
      wait (pending_reqs.size() == 0);
    end
    wait (expected_results.size() == 0 && !busy);
    repeat (20) @(posedge clk);
    stim_done = 1'b1;
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("decimal_bcd_alu verification clean");
    else
      $display("decimal_bcd_alu verification failed");
    $finish;
  end

  // Watchdog: fail the run if the stimulus does not finish.
  initial begin
    #1000ms;
    if (!stim_done) begin
      $display("decimal_bcd_alu verification failed");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
rtl/dba_pkg.sv
rtl/dba_digit_unit.sv
rtl/decimal_bcd_alu.sv
tb/sv/tb_decimal_bcd_alu.sv
